### sv/ebt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebt_pkg
// Shared types, codes and the prescaler table of the 8-bit timer with PWM.
// ----------------------------------------------------------------------------
package ebt_pkg;

   // item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // register addresses
   localparam logic [2:0] ADDR_CONTROL = 3'd0;
   localparam logic [2:0] ADDR_COUNT   = 3'd1;
   localparam logic [2:0] ADDR_COMPARE = 3'd2;
   localparam logic [2:0] ADDR_IRQ_EN  = 3'd3;
   localparam logic [2:0] ADDR_FLAGS   = 3'd4;

   // waveform modes, {WGM1, WGM0}
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_PHASE  = 2'd1;
   localparam logic [1:0] MODE_CTC    = 2'd2;
   localparam logic [1:0] MODE_FAST   = 2'd3;

   // compare output actions
   localparam logic [1:0] COM_OFF    = 2'd0;
   localparam logic [1:0] COM_TOGGLE = 2'd1;
   localparam logic [1:0] COM_CLEAR  = 2'd2;
   localparam logic [1:0] COM_SET    = 2'd3;

   // flag bit positions
   localparam int FLAG_OVF   = 0;
   localparam int FLAG_MATCH = 1;

   // request word
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] reg_addr;
      logic [7:0] write_data;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [7:0] read_data;
      logic       overflow_flag;
      logic       match_flag;
      logic       irq;
      logic       wave_out;
   } rsp_word_type;

   // prescaler divisor for a clock select code, zero means stopped
   function automatic logic [10:0] clock_divisor(input logic [2:0] cs);
      logic [10:0] div;
      begin
         unique case (cs)
            3'd0: div = 11'd0;
            3'd1: div = 11'd1;
            3'd2: div = 11'd8;
            3'd3: div = 11'd32;
            3'd4: div = 11'd64;
            3'd5: div = 11'd128;
            3'd6: div = 11'd256;
            3'd7: div = 11'd1024;
            default: div = 11'd0;
         endcase
         clock_divisor = div;
      end
   endfunction

endpackage

### sv/ebt_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebt_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface ebt_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/eight_bit_timer_with_pwm.sv
`timescale 1ns / 1ps
// Throughput is one word per clock: a tick, register write or register read
// is taken every cycle while the response side keeps up. Each word is held
// in the input register and is then applied to the timer state, with its
// response landing in the output register, from which it is offered on the
// response channel. The update of the counter, prescaler and flags in the
// core, done as each word leaves the input register, sets that rate.
// ----------------------------------------------------------------------------
// eight_bit_timer_with_pwm
// 8-bit timer/counter with prescaler, CTC and PWM modes, compare output and
// masked interrupt, behind a valid/ready request and response channel.
// ----------------------------------------------------------------------------
module eight_bit_timer_with_pwm #(
   parameter int COUNT_BITS = 8
) (
   input logic         clock,
   input logic         reset,
   ebt_chan_if.sink    req_chan,
   ebt_chan_if.source  rsp_chan
);

   // input register
   logic                  in_valid_ff, in_valid_in;
   ebt_pkg::req_word_type in_word_ff;

   // output register
   logic                  out_valid_ff, out_valid_in;
   ebt_pkg::rsp_word_type out_word_ff;

   logic                  advance;
   logic                  step_en;
   logic                  req_take;
   ebt_pkg::rsp_word_type step_result;

   // pipeline moves when the output register is free or being emptied
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign step_en  = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) in_word_ff <= req_chan.payload;
      if (step_en)  out_word_ff <= step_result;
   end

   // timer state and update
   ebt_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_word_ff),
      .result  (step_result)
   );

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

endmodule

### sv/ebt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebt_core
// Timer state and its update for one word: prescaler, counter,
// waveform modes, compare buffering, flags and register access.
// ----------------------------------------------------------------------------
module ebt_core #(
   parameter int COUNT_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  ebt_pkg::req_word_type item,
   output ebt_pkg::rsp_word_type result
);

   localparam logic [COUNT_BITS-1:0] CNT_TOP  = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_ZERO = {COUNT_BITS{1'b0}};
   localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

   // state
   logic [6:0]            ctrl_ff,  ctrl_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]            cmp_ff,   cmp_in;
   logic [7:0]            buf_ff,   buf_in;
   logic [9:0]            psc_ff,   psc_in;
   logic [1:0]            irqen_ff, irqen_in;
   logic [1:0]            flag_ff,  flag_in;
   logic                  pin_ff,   pin_in;
   logic                  down_ff,  down_in;

   // control fields
   logic [1:0]  mode;
   logic [1:0]  com;
   logic [10:0] divisor;
   logic        pwm_mode;

   assign mode     = {ctrl_ff[3], ctrl_ff[6]};
   assign com      = ctrl_ff[5:4];
   assign divisor  = ebt_pkg::clock_divisor(ctrl_ff[2:0]);
   assign pwm_mode = (mode == ebt_pkg::MODE_PHASE) || (mode == ebt_pkg::MODE_FAST);

   // outcome of one timer clock
   logic [COUNT_BITS-1:0] tc_count;
   logic [7:0]            tc_cmp;
   logic [1:0]            tc_flag;
   logic                  tc_pin;
   logic                  tc_down;

   always_comb begin
      logic dn;
      dn       = down_ff;
      tc_count = count_ff + CNT_ONE;
      tc_cmp   = cmp_ff;
      tc_flag  = flag_ff;
      tc_pin   = pin_ff;
      tc_down  = down_ff;
      unique case (mode)
         ebt_pkg::MODE_PHASE: begin
            // up to top, back down to bottom
            if (count_ff == CNT_TOP) dn = 1'b1;
            if (count_ff == CNT_ZERO) dn = 1'b0;
            tc_count = dn ? (count_ff - CNT_ONE) : (count_ff + CNT_ONE);
            if (tc_count == CNT_TOP) dn = 1'b1;
            else if (tc_count == CNT_ZERO) dn = 1'b0;
            tc_down = dn;
            if (tc_count == CNT_TOP) tc_cmp = buf_ff;
            if (tc_count == CNT_ZERO) tc_flag[ebt_pkg::FLAG_OVF] = 1'b1;
            if (tc_count == COUNT_BITS'(tc_cmp)) begin
               tc_flag[ebt_pkg::FLAG_MATCH] = 1'b1;
               if (com == ebt_pkg::COM_CLEAR || com == ebt_pkg::COM_SET) begin
                  tc_pin = dn ? (com == ebt_pkg::COM_CLEAR) : (com == ebt_pkg::COM_SET);
               end
            end
         end
         ebt_pkg::MODE_FAST: begin
            // bottom reloads the compare value and starts the pulse
            if (tc_count == CNT_ZERO) begin
               tc_flag[ebt_pkg::FLAG_OVF] = 1'b1;
               tc_cmp = buf_ff;
               if (com == ebt_pkg::COM_CLEAR || com == ebt_pkg::COM_SET) begin
                  tc_pin = (com == ebt_pkg::COM_CLEAR);
               end
            end
            if (tc_count == COUNT_BITS'(tc_cmp)) begin
               tc_flag[ebt_pkg::FLAG_MATCH] = 1'b1;
               if ((com == ebt_pkg::COM_CLEAR || com == ebt_pkg::COM_SET) &&
                   tc_count != CNT_TOP) begin
                  tc_pin = (com == ebt_pkg::COM_SET);
               end
            end
         end
         ebt_pkg::MODE_NORMAL, ebt_pkg::MODE_CTC: begin
            if (mode == ebt_pkg::MODE_CTC && count_ff == COUNT_BITS'(cmp_ff)) begin
               tc_count = CNT_ZERO;
            end else if (count_ff == CNT_TOP) begin
               tc_flag[ebt_pkg::FLAG_OVF] = 1'b1;
            end
            if (tc_count == COUNT_BITS'(cmp_ff)) begin
               tc_flag[ebt_pkg::FLAG_MATCH] = 1'b1;
               unique case (com)
                  ebt_pkg::COM_TOGGLE: tc_pin = ~pin_ff;
                  ebt_pkg::COM_CLEAR:  tc_pin = 1'b0;
                  ebt_pkg::COM_SET:    tc_pin = 1'b1;
                  ebt_pkg::COM_OFF:    tc_pin = pin_ff;
               endcase
            end
         end
      endcase
   end

   // step: tick, register write or register read
   logic [10:0] psc_inc;
   logic [7:0]  rd_data;

   assign psc_inc = {1'b0, psc_ff} + 11'd1;

   always_comb begin
      ctrl_in  = ctrl_ff;
      count_in = count_ff;
      cmp_in   = cmp_ff;
      buf_in   = buf_ff;
      psc_in   = psc_ff;
      irqen_in = irqen_ff;
      flag_in  = flag_ff;
      pin_in   = pin_ff;
      down_in  = down_ff;
      rd_data  = 8'd0;
      unique case (item.kind)
         ebt_pkg::KIND_TICK: begin
            if (divisor != 11'd0) begin
               if (psc_inc >= divisor) begin
                  psc_in   = 10'd0;
                  count_in = tc_count;
                  cmp_in   = tc_cmp;
                  flag_in  = tc_flag;
                  pin_in   = tc_pin;
                  down_in  = tc_down;
               end else begin
                  psc_in = psc_inc[9:0];
               end
            end
         end
         ebt_pkg::KIND_WRITE: begin
            unique case (item.reg_addr)
               ebt_pkg::ADDR_CONTROL: ctrl_in  = item.write_data[6:0];
               ebt_pkg::ADDR_COUNT:   count_in = COUNT_BITS'(item.write_data);
               ebt_pkg::ADDR_COMPARE: begin
                  buf_in = item.write_data;
                  if (!pwm_mode) cmp_in = item.write_data;
               end
               ebt_pkg::ADDR_IRQ_EN:  irqen_in = item.write_data[1:0];
               ebt_pkg::ADDR_FLAGS:   flag_in  = flag_ff & ~item.write_data[1:0];
               default: ;
            endcase
         end
         ebt_pkg::KIND_READ: begin
            unique case (item.reg_addr)
               ebt_pkg::ADDR_CONTROL: rd_data = {1'b0, ctrl_ff};
               ebt_pkg::ADDR_COUNT:   rd_data = count_ff[7:0];
               ebt_pkg::ADDR_COMPARE: rd_data = buf_ff;
               ebt_pkg::ADDR_IRQ_EN:  rd_data = {6'd0, irqen_ff};
               ebt_pkg::ADDR_FLAGS:   rd_data = {6'd0, flag_ff};
               default:               rd_data = 8'd0;
            endcase
         end
         default: ;
      endcase
   end

   // result shows the state after the step
   always_comb begin
      result.read_data     = rd_data;
      result.overflow_flag = flag_in[ebt_pkg::FLAG_OVF];
      result.match_flag    = flag_in[ebt_pkg::FLAG_MATCH];
      result.irq           = |(flag_in & irqen_in);
      result.wave_out      = pin_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff  <= '0;
         count_ff <= '0;
         cmp_ff   <= '0;
         buf_ff   <= '0;
         psc_ff   <= '0;
         irqen_ff <= '0;
         flag_ff  <= '0;
         pin_ff   <= 1'b0;
         down_ff  <= 1'b0;
      end else if (step_en) begin
         ctrl_ff  <= ctrl_in;
         count_ff <= count_in;
         cmp_ff   <= cmp_in;
         buf_ff   <= buf_in;
         psc_ff   <= psc_in;
         irqen_ff <= irqen_in;
         flag_ff  <= flag_in;
         pin_ff   <= pin_in;
         down_ff  <= down_in;
      end
   end

   // no word, no change
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(count_ff) && $stable(flag_ff) && $stable(pin_ff))
      else $error("timer state changed without a word");

   // reads leave the timer alone
   a_read_no_effect: assert property (@(posedge clock) disable iff (reset)
      step_en && item.kind == ebt_pkg::KIND_READ
      |=> $stable(count_ff) && $stable(ctrl_ff) && $stable(flag_ff) && $stable(psc_ff))
      else $error("register read changed timer state");

   // stopped clock: ticks do not advance count or prescaler
   a_stopped_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && item.kind == ebt_pkg::KIND_TICK && divisor == 11'd0
      |=> $stable(count_ff) && $stable(psc_ff))
      else $error("stopped timer advanced");

   // writing ones to both flag bits clears them
   a_flag_clear: assert property (@(posedge clock) disable iff (reset)
      step_en && item.kind == ebt_pkg::KIND_WRITE && item.reg_addr == ebt_pkg::ADDR_FLAGS &&
      item.write_data[1:0] == 2'b11
      |=> flag_ff == 2'b00)
      else $error("flag clear did not take effect");

endmodule
